@@ rtl/ffsa_pkg.sv @@
// Shared types and constants for the first-fit segment allocator
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int DEF_MAX_BLOCKS   = 8;
  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_ADDR_BITS    = 32;

  localparam logic [4:0]  RST_ALIGN_LOG2    = 5'd8;
  localparam logic [31:0] RST_NEW_BLOCK_LEN = 32'(16 * 1024 * 1024);

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic CFG_ALIGN_LOG2    = 1'b0;
  localparam logic CFG_NEW_BLOCK_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_NEW      = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_RELEASED = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_FULL     = 3'd5,
    ST_TOO_BIG  = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_READ,
    DP_INC_S,
    DP_INC_B,
    DP_SHRINK,
    DP_GRANT,
    DP_NEWBLK,
    DP_READ_K1,
    DP_WRITE_K,
    DP_DEC_CNT,
    DP_RCMP,
    DP_WR_BOTH,
    DP_WR_LEFT,
    DP_WR_RIGHT,
    DP_APPEND,
    DP_SU_INIT,
    DP_READ_KM1,
    DP_WRITE_K_DN,
    DP_SU_DONE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } ctl_cmd_t;

  typedef struct packed {
    logic ovf;
    logic is_alloc;
    logic blk_ok;
    logic seg_ok;
    logic fit;
    logic exact;
    logic k_more;
    logic k_nz;
    logic has_left;
    logic has_right;
    logic full;
    logic off_zero;
    logic all_open;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/ffsa_datapath.sv @@
// Segment tables, block counts, arithmetic and result register of the allocator
`timescale 1ns / 1ps
module ffsa_datapath
  import ffsa_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_op,
  input  logic [31:0] in_request_size,
  input  logic [2:0]  in_block_index,
  input  logic [31:0] in_release_offset,
  input  logic [31:0] in_release_length,
  input  ctl_cmd_t    cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_granted_block,
  output logic [31:0] out_granted_offset,
  output logic [31:0] out_granted_length
);

  localparam int BB    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NBK   = 1 << BB;
  localparam int OW    = $clog2(MAX_BLOCKS + 1);
  localparam int XBW   = (OW > 3) ? OW : 3;
  localparam int SB    = $clog2(MAX_SEGMENTS);
  localparam int CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int DEPTH = 1 << (BB + SB);
  localparam int A     = ADDR_BITS;
  localparam int XW    = (ADDR_BITS > 32) ? ADDR_BITS + 2 : 34;

  logic [A-1:0]   mem_start [DEPTH];
  logic [A-1:0]   mem_len   [DEPTH];

  logic [4:0]     align_r;
  logic [31:0]    nbl_r;
  logic [OW-1:0]  blocks_open_r;
  logic [CW-1:0]  cnt_r [NBK];
  logic           out_valid_r;

  logic [XBW-1:0] b_r;
  logic [CW-1:0]  s_r;
  logic [CW-1:0]  k_r;
  logic           op_r;
  logic           ovf_r;
  logic [A-1:0]   aligned_r;
  logic [A-1:0]   off_r;
  logic [A-1:0]   len_r;
  logic [A-1:0]   rd_start_r;
  logic [A-1:0]   rd_len_r;
  logic [BB-1:0]  g_blk_r;
  logic [A-1:0]   g_off_r;
  logic           has_left_r;
  logic           has_right_r;
  logic [SB-1:0]  left_r;
  logic [SB-1:0]  right_r;
  logic [A-1:0]   ls_r;
  logic [A-1:0]   rs_r;
  logic [A-1:0]   rl_r;
  logic [2:0]     out_status_r;
  logic [2:0]     out_blk_r;
  logic [31:0]    out_off_r;
  logic [31:0]    out_len_r;

  logic [BB-1:0]  bsel;
  logic [CW-1:0]  cur_cnt;
  logic [XW-1:0]  am;
  logic [XW-1:0]  aligned_x;
  logic [XW-1:0]  nbl_x;
  logic [XW-1:0]  off_x;
  logic [XW-1:0]  len_x;
  logic [A-1:0]   blk_len;
  logic [A-1:0]   new_len;
  logic           new_rest;
  logic [CW-1:0]  k_plus;
  logic [CW-1:0]  k_minus;
  logic [A:0]     lsum;
  logic [A:0]     rsum;
  logic           lmatch;
  logic           rmatch;
  logic           re;
  logic [SB-1:0]  ridx;
  logic           we;
  logic [BB-1:0]  wblk;
  logic [SB-1:0]  widx;
  logic [A-1:0]   wstart;
  logic [A-1:0]   wlen;
  logic           out_free;

  assign bsel      = b_r[BB-1:0];
  assign cur_cnt   = cnt_r[bsel];
  assign am        = (XW'(1) << align_r) - XW'(1);
  assign aligned_x = (XW'(in_request_size) + am) & ~am;
  assign nbl_x     = XW'(nbl_r);
  assign blk_len   = (|(nbl_x >> A)) ? '1 : nbl_x[A-1:0];
  assign new_len   = (blk_len > aligned_r) ? blk_len : aligned_r;
  assign new_rest  = new_len > aligned_r;
  assign off_x     = XW'(in_release_offset);
  assign len_x     = XW'(in_release_length);
  assign k_plus    = k_r + CW'(1);
  assign k_minus   = k_r - CW'(1);
  assign lsum      = {1'b0, rd_start_r} + {1'b0, rd_len_r};
  assign rsum      = {1'b0, off_r} + {1'b0, len_r};
  assign lmatch    = lsum == {1'b0, off_r};
  assign rmatch    = rsum == {1'b0, rd_start_r};
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    stat.ovf       = ovf_r;
    stat.is_alloc  = op_r == OP_ALLOC;
    stat.blk_ok    = b_r < XBW'(blocks_open_r);
    stat.seg_ok    = s_r < cur_cnt;
    stat.fit       = rd_len_r >= aligned_r;
    stat.exact     = rd_len_r == aligned_r;
    stat.k_more    = k_plus < cur_cnt;
    stat.k_nz      = k_r != '0;
    stat.has_left  = has_left_r;
    stat.has_right = has_right_r;
    stat.full      = cur_cnt >= CW'(MAX_SEGMENTS);
    stat.off_zero  = off_r == '0;
    stat.all_open  = blocks_open_r >= OW'(MAX_BLOCKS);
    stat.out_free  = out_free;
  end

  always_comb begin
    re   = 1'b0;
    ridx = s_r[SB-1:0];
    case (cmd.op)
      DP_READ: begin
        re = 1'b1;
      end
      DP_READ_K1: begin
        re   = 1'b1;
        ridx = k_plus[SB-1:0];
      end
      DP_READ_KM1: begin
        re   = 1'b1;
        ridx = k_minus[SB-1:0];
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_comb begin
    we     = 1'b0;
    wblk   = bsel;
    widx   = k_r[SB-1:0];
    wstart = rd_start_r;
    wlen   = rd_len_r;
    case (cmd.op)
      DP_SHRINK: begin
        we     = 1'b1;
        widx   = s_r[SB-1:0];
        wstart = rd_start_r + aligned_r;
        wlen   = rd_len_r - aligned_r;
      end
      DP_WRITE_K, DP_WRITE_K_DN: begin
        we = 1'b1;
      end
      DP_NEWBLK: begin
        we     = new_rest;
        wblk   = blocks_open_r[BB-1:0];
        widx   = '0;
        wstart = aligned_r;
        wlen   = new_len - aligned_r;
      end
      DP_WR_BOTH: begin
        we     = 1'b1;
        widx   = left_r;
        wstart = ls_r;
        wlen   = rs_r + rl_r - ls_r;
      end
      DP_WR_LEFT: begin
        we     = 1'b1;
        widx   = left_r;
        wstart = ls_r;
        wlen   = off_r + len_r - ls_r;
      end
      DP_WR_RIGHT: begin
        we     = 1'b1;
        widx   = right_r;
        wstart = off_r;
        wlen   = rs_r + rl_r - off_r;
      end
      DP_APPEND: begin
        we     = 1'b1;
        widx   = cur_cnt[SB-1:0];
        wstart = off_r;
        wlen   = len_r;
      end
      DP_SU_DONE: begin
        we     = 1'b1;
        widx   = '0;
        wstart = off_r;
        wlen   = len_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[{wblk, widx}] <= wstart;
      mem_len[{wblk, widx}]   <= wlen;
    end
    if (re) begin
      rd_start_r <= mem_start[{bsel, ridx}];
      rd_len_r   <= mem_len[{bsel, ridx}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r       <= RST_ALIGN_LOG2;
      nbl_r         <= RST_NEW_BLOCK_LEN;
      blocks_open_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NBK; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALIGN_LOG2:    align_r <= cfg_wdata[4:0];
          CFG_NEW_BLOCK_LEN: nbl_r   <= cfg_wdata;
          default:           nbl_r   <= nbl_r;
        endcase
      end
      case (cmd.op)
        DP_NEWBLK: begin
          blocks_open_r                  <= blocks_open_r + OW'(1);
          cnt_r[blocks_open_r[BB-1:0]]   <= new_rest ? CW'(1) : '0;
        end
        DP_DEC_CNT: begin
          cnt_r[bsel] <= cur_cnt - CW'(1);
        end
        DP_APPEND, DP_SU_DONE: begin
          cnt_r[bsel] <= cur_cnt + CW'(1);
        end
        default: begin
          blocks_open_r <= blocks_open_r;
        end
      endcase
      if (cmd.op == DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_r        <= in_op;
        ovf_r       <= |(aligned_x >> A);
        aligned_r   <= aligned_x[A-1:0];
        off_r       <= off_x[A-1:0];
        len_r       <= len_x[A-1:0];
        b_r         <= (in_op == OP_RELEASE) ? XBW'(in_block_index) : '0;
        s_r         <= '0;
        has_left_r  <= 1'b0;
        has_right_r <= 1'b0;
      end
      DP_INC_S: begin
        s_r <= s_r + CW'(1);
      end
      DP_INC_B: begin
        b_r <= b_r + XBW'(1);
        s_r <= '0;
      end
      DP_SHRINK: begin
        g_blk_r <= bsel;
        g_off_r <= rd_start_r;
      end
      DP_GRANT: begin
        g_blk_r <= bsel;
        g_off_r <= rd_start_r;
        k_r     <= s_r;
      end
      DP_NEWBLK: begin
        g_blk_r <= blocks_open_r[BB-1:0];
        g_off_r <= '0;
      end
      DP_RCMP: begin
        if (lmatch) begin
          left_r     <= s_r[SB-1:0];
          ls_r       <= rd_start_r;
          has_left_r <= 1'b1;
        end else if (rmatch) begin
          right_r     <= s_r[SB-1:0];
          rs_r        <= rd_start_r;
          rl_r        <= rd_len_r;
          has_right_r <= 1'b1;
        end
        s_r <= s_r + CW'(1);
      end
      DP_WR_BOTH: begin
        k_r <= CW'(right_r);
      end
      DP_SU_INIT: begin
        k_r <= cur_cnt;
      end
      DP_WRITE_K: begin
        k_r <= k_plus;
      end
      DP_WRITE_K_DN: begin
        k_r <= k_minus;
      end
      DP_EMIT: begin
        out_status_r <= cmd.status;
        if (cmd.status == ST_FREE || cmd.status == ST_NEW) begin
          out_blk_r <= 3'(g_blk_r);
          out_off_r <= 32'(g_off_r);
          out_len_r <= 32'(aligned_r);
        end else begin
          out_blk_r <= '0;
          out_off_r <= '0;
          out_len_r <= '0;
        end
      end
      default: begin
        s_r <= s_r;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_block  = out_blk_r;
  assign out_granted_offset = out_off_r;
  assign out_granted_length = out_len_r;

  a_blocks_bound: assert property (@(posedge clk) disable iff (!rst_n)
    blocks_open_r <= OW'(MAX_BLOCKS))
    else $error("open block count beyond limit");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(b_r) |-> cur_cnt <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond limit");

  a_newblk_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_NEWBLK |-> blocks_open_r < OW'(MAX_BLOCKS))
    else $error("new block opened with no free slot");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_EMIT |-> out_free)
    else $error("result loaded over a pending beat");

  a_grow_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_APPEND || cmd.op == DP_SU_DONE) |-> cur_cnt < CW'(MAX_SEGMENTS))
    else $error("segment added to a full list");

endmodule

@@ rtl/ffsa_ctrl.sv @@
// Sequencer for allocate scans, list shifts, release merges and result hand-off
`timescale 1ns / 1ps
module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_CHK,
    S_A_CMP,
    S_A_NONE,
    S_SD_CHK,
    S_SD_WR,
    S_R_CHK,
    S_R_CMP,
    S_R_RES,
    S_SU_CHK,
    S_SU_WR,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd.op     = DP_NOP;
    cmd.status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_alloc) begin
          if (stat.ovf) begin
            status_nxt = ST_TOO_BIG;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_A_CHK;
          end
        end else if (!stat.blk_ok) begin
          status_nxt = ST_UNKNOWN;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_R_CHK;
        end
      end
      S_A_CHK: begin
        if (!stat.blk_ok) begin
          state_nxt = S_A_NONE;
        end else if (!stat.seg_ok) begin
          cmd.op = DP_INC_B;
        end else begin
          cmd.op    = DP_READ;
          state_nxt = S_A_CMP;
        end
      end
      S_A_CMP: begin
        if (stat.fit) begin
          status_nxt = ST_FREE;
          if (stat.exact) begin
            cmd.op    = DP_GRANT;
            state_nxt = S_SD_CHK;
          end else begin
            cmd.op    = DP_SHRINK;
            state_nxt = S_EMIT;
          end
        end else begin
          cmd.op    = DP_INC_S;
          state_nxt = S_A_CHK;
        end
      end
      S_A_NONE: begin
        state_nxt = S_EMIT;
        if (stat.all_open) begin
          status_nxt = ST_NO_SLOT;
        end else begin
          cmd.op     = DP_NEWBLK;
          status_nxt = ST_NEW;
        end
      end
      S_SD_CHK: begin
        if (stat.k_more) begin
          cmd.op    = DP_READ_K1;
          state_nxt = S_SD_WR;
        end else begin
          cmd.op    = DP_DEC_CNT;
          state_nxt = S_EMIT;
        end
      end
      S_SD_WR: begin
        cmd.op    = DP_WRITE_K;
        state_nxt = S_SD_CHK;
      end
      S_R_CHK: begin
        if (stat.seg_ok) begin
          cmd.op    = DP_READ;
          state_nxt = S_R_CMP;
        end else begin
          state_nxt = S_R_RES;
        end
      end
      S_R_CMP: begin
        cmd.op    = DP_RCMP;
        state_nxt = S_R_CHK;
      end
      S_R_RES: begin
        status_nxt = ST_RELEASED;
        state_nxt  = S_EMIT;
        if (stat.has_left && stat.has_right) begin
          cmd.op    = DP_WR_BOTH;
          state_nxt = S_SD_CHK;
        end else if (stat.has_left) begin
          cmd.op = DP_WR_LEFT;
        end else if (stat.has_right) begin
          cmd.op = DP_WR_RIGHT;
        end else if (stat.full) begin
          status_nxt = ST_FULL;
        end else if (stat.off_zero) begin
          cmd.op    = DP_SU_INIT;
          state_nxt = S_SU_CHK;
        end else begin
          cmd.op = DP_APPEND;
        end
      end
      S_SU_CHK: begin
        if (stat.k_nz) begin
          cmd.op    = DP_READ_KM1;
          state_nxt = S_SU_WR;
        end else begin
          cmd.op    = DP_SU_DONE;
          state_nxt = S_EMIT;
        end
      end
      S_SU_WR: begin
        cmd.op    = DP_WRITE_K_DN;
        state_nxt = S_SU_CHK;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_FREE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

@@ rtl/first_fit_segment_allocator.sv @@
// Allocate scans segments block by block, then shifts entries down when a fit is exact.
// Release scans every segment of the block, then shifts entries on a merge or front insert.
// One item at a time: in_stall stays high from accept until the result is loaded into the output register.
// Synchronous reset clears open blocks and counts and restores config defaults; segment memory is not cleared.
`timescale 1ns / 1ps
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_request_size,
  input  logic [2:0]  in_block_index,
  input  logic [31:0] in_release_offset,
  input  logic [31:0] in_release_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_granted_block,
  output logic [31:0] out_granted_offset,
  output logic [31:0] out_granted_length
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffsa_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_op              (in_op),
    .in_request_size    (in_request_size),
    .in_block_index     (in_block_index),
    .in_release_offset  (in_release_offset),
    .in_release_length  (in_release_length),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_block  (out_granted_block),
    .out_granted_offset (out_granted_offset),
    .out_granted_length (out_granted_length)
  );

endmodule

@@ tb/tb_first_fit_segment_allocator.sv @@
// Testbench for the first-fit segment allocator: random and directed beats checked against a model
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;

  localparam int NBLK = 8;
  localparam int NSEG = 16;

  typedef struct {
    logic        op;
    logic [31:0] size;
    logic [2:0]  blk;
    logic [31:0] off;
    logic [31:0] len;
  } req_t;

  typedef struct {
    status_t     st;
    logic [2:0]  blk;
    logic [31:0] off;
    logic [31:0] len;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [31:0] in_request_size = '0;
  logic [2:0]  in_block_index = '0;
  logic [31:0] in_release_offset = '0;
  logic [31:0] in_release_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [2:0]  out_status;
  logic [2:0]  out_granted_block;
  logic [31:0] out_granted_offset;
  logic [31:0] out_granted_length;

  first_fit_segment_allocator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // allocator model state
  logic [4:0]  m_align;
  logic [31:0] m_blklen;
  int          m_open;
  logic [31:0] m_start [NBLK][NSEG];
  logic [31:0] m_len [NBLK][NSEG];
  int          m_cnt [NBLK];

  req_t   pending_reqs [$];
  grant_t expected_grants [$];
  int     errors = 0;
  int     hold_off = 0;

  function automatic void remove_seg(int b, int s);
    for (int k = s; k + 1 < m_cnt[b]; k++) begin
      m_start[b][k] = m_start[b][k + 1];
      m_len[b][k] = m_len[b][k + 1];
    end
    m_cnt[b]--;
  endfunction

  function automatic grant_t allocate(logic [31:0] size);
    grant_t g;
    logic [63:0] a;
    logic [63:0] al;
    logic [63:0] nl;
    g = '{ST_FREE, 3'd0, 32'd0, 32'd0};
    a = 64'd1 << m_align;
    al = ({32'd0, size} + a - 64'd1) & ~(a - 64'd1);
    if (al > 64'hFFFF_FFFF) begin
      g.st = ST_TOO_BIG;
      return g;
    end
    for (int b = 0; b < m_open; b++) begin
      for (int s = 0; s < m_cnt[b]; s++) begin
        if ({32'd0, m_len[b][s]} >= al) begin
          g.blk = 3'(b);
          g.off = m_start[b][s];
          g.len = al[31:0];
          if ({32'd0, m_len[b][s]} == al) remove_seg(b, s);
          else begin
            m_start[b][s] = m_start[b][s] + al[31:0];
            m_len[b][s] = m_len[b][s] - al[31:0];
          end
          return g;
        end
      end
    end
    if (m_open >= NBLK) begin
      g.st = ST_NO_SLOT;
      return g;
    end
    nl = ({32'd0, m_blklen} > al) ? {32'd0, m_blklen} : al;
    m_cnt[m_open] = 0;
    if (nl > al) begin
      m_start[m_open][0] = al[31:0];
      m_len[m_open][0] = nl[31:0] - al[31:0];
      m_cnt[m_open] = 1;
    end
    g.st = ST_NEW;
    g.blk = 3'(m_open);
    g.len = al[31:0];
    m_open++;
    return g;
  endfunction

  function automatic grant_t release_range(int b, logic [31:0] off, logic [31:0] len);
    grant_t g;
    int l;
    int r;
    bit hl;
    bit hr;
    int n;
    g = '{ST_RELEASED, 3'd0, 32'd0, 32'd0};
    l = 0; r = 0; hl = 0; hr = 0;
    if (b >= m_open) begin
      g.st = ST_UNKNOWN;
      return g;
    end
    n = m_cnt[b];
    for (int s = 0; s < n; s++) begin
      if ({1'b0, m_start[b][s]} + {1'b0, m_len[b][s]} == {1'b0, off}) begin
        l = s; hl = 1;
      end else if ({1'b0, off} + {1'b0, len} == {1'b0, m_start[b][s]}) begin
        r = s; hr = 1;
      end
    end
    if (hl && hr) begin
      m_len[b][l] = m_start[b][r] + m_len[b][r] - m_start[b][l];
      remove_seg(b, r);
    end else if (hl) begin
      m_len[b][l] = off + len - m_start[b][l];
    end else if (hr) begin
      m_len[b][r] = m_start[b][r] + m_len[b][r] - off;
      m_start[b][r] = off;
    end else begin
      if (n >= NSEG) begin
        g.st = ST_FULL;
        return g;
      end
      if (off == 0) begin
        for (int s = n; s > 0; s--) begin
          m_start[b][s] = m_start[b][s - 1];
          m_len[b][s] = m_len[b][s - 1];
        end
        m_start[b][0] = off;
        m_len[b][0] = len;
      end else begin
        m_start[b][n] = off;
        m_len[b][n] = len;
      end
      m_cnt[b] = n + 1;
    end
    return g;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // capture stall at the edge so the driver sees the accepting edge's value
  logic in_stall_s = 1'b1;

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_s) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_reqs.size() > 0) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_op <= r.op;
          in_request_size <= r.size;
          in_block_index <= r.blk;
          in_release_offset <= r.off;
          in_release_length <= r.len;
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    in_stall_s <= in_stall;
    if (rst_n && in_valid && !in_stall) begin
      grant_t g;
      if (in_op == OP_ALLOC) g = allocate(in_request_size);
      else g = release_range(int'(in_block_index), in_release_offset, in_release_length);
      expected_grants = {expected_grants, g};
    end
  end

  // receiver stall
  int out_gap = 0;
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) out_gap = 0;
      out_stall <= (out_gap != 0);
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= (out_gap != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        report("unexpected beat status", 32'(out_status), 32'd0);
      end else begin
        grant_t e;
        e = expected_grants.pop_front();
        if (out_status !== e.st) report("status", 32'(out_status), 32'(e.st));
        if (out_granted_block !== e.blk) report("block", 32'(out_granted_block), 32'(e.blk));
        if (out_granted_offset !== e.off) report("offset", out_granted_offset, e.off);
        if (out_granted_length !== e.len) report("length", out_granted_length, e.len);
      end
    end
  end

  task automatic push_alloc(logic [31:0] size);
    req_t r;
    r = '{OP_ALLOC, size, 3'd0, 32'd0, 32'd0};
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic push_release(logic [2:0] b, logic [31:0] off, logic [31:0] len);
    req_t r;
    r = '{OP_RELEASE, $urandom, b, off, len};
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ALIGN_LOG2) m_align = val[4:0];
    else m_blklen = val;
  endtask

  // random phase: mix of allocates and releases near granted ranges, some noise
  task automatic random_phase(int items, int max_size);
    for (int i = 0; i < items; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) push_alloc($urandom_range(0, max_size));
      else if (pick < 55) push_alloc($urandom);
      else if (pick < 88) begin
        push_release(3'($urandom_range(0, 7)), $urandom_range(0, 4) * 32'h100,
                     $urandom_range(1, 8) * 32'h100);
      end else if (pick < 95) begin
        push_release(3'($urandom), $urandom_range(0, 64) * 32'h40, $urandom_range(0, 4096));
      end else begin
        push_release(3'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    m_align = RST_ALIGN_LOG2;
    m_blklen = RST_NEW_BLOCK_LEN;
    m_open = 0;
    foreach (m_cnt[b]) m_cnt[b] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults, then extremes
    push_alloc(32'd0);
    push_alloc(32'd1);
    push_alloc(32'd256);
    push_alloc(32'hFFFF_FFFF);
    push_release(3'd0, 32'd0, 32'd256);
    push_release(3'd0, 32'd512, 32'd256);
    push_release(3'd0, 32'd256, 32'd256);
    push_release(3'd7, 32'd0, 32'd16);
    push_alloc(32'd300);
    wait_idle();

    write_cfg(CFG_ALIGN_LOG2, 32'd0);
    write_cfg(CFG_NEW_BLOCK_LEN, 32'd1);
    push_alloc(32'hFFFF_FFFF);
    push_alloc(32'd5);
    push_alloc(32'd0);
    for (int b = 0; b < 6; b++) push_alloc(32'd1 << (b + 1));
    push_alloc(32'd100);
    for (int i = 0; i < 17; i++) push_release(3'd2, 32'd10 + 32'(i) * 3, 32'd1);
    push_release(3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // long hold-off while the sender keeps offering beats
    write_cfg(CFG_ALIGN_LOG2, 32'd31);
    hold_off = 400;
    push_alloc(32'd0);
    push_alloc(32'd1);
    wait_idle();
    write_cfg(CFG_ALIGN_LOG2, 32'd16);
    write_cfg(CFG_NEW_BLOCK_LEN, 32'hFFFF_FFFF);
    push_alloc(32'hFFFF_0001);
    push_alloc(32'h0001_0000);
    wait_idle();

    write_cfg(CFG_ALIGN_LOG2, 32'd6);
    write_cfg(CFG_NEW_BLOCK_LEN, 32'h800);
    random_phase(250, 32'h300);
    wait_idle();
    write_cfg(CFG_ALIGN_LOG2, 32'd8);
    write_cfg(CFG_NEW_BLOCK_LEN, 32'h1000);
    random_phase(250, 32'h400);
    wait_idle();
    write_cfg(CFG_ALIGN_LOG2, 32'd2);
    write_cfg(CFG_NEW_BLOCK_LEN, 32'h40);
    random_phase(220, 32'h80);
    wait_idle();

    if (errors == 0) $display("tb_first_fit_segment_allocator: done, clean");
    else $display("tb_first_fit_segment_allocator: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_first_fit_segment_allocator: done, errors");
    $finish;
  end

endmodule

@@ first_fit_segment_allocator.f @@
rtl/ffsa_pkg.sv
rtl/ffsa_datapath.sv
rtl/ffsa_ctrl.sv
rtl/first_fit_segment_allocator.sv
tb/tb_first_fit_segment_allocator.sv
